// File: sv/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: sv/ppdc_pkg.sv
// Package: types, constants and codes for the push/pop discipline checker
`timescale 1ns / 1ps
package ppdc_pkg;
    localparam int DEPTH      = 1024;
    localparam int VALUE_BITS = 16;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);

    localparam logic [2:0] VERDICT_IMPOSSIBLE = 3'd0;
    localparam logic [2:0] VERDICT_STACK      = 3'd1;
    localparam logic [2:0] VERDICT_QUEUE      = 3'd2;
    localparam logic [2:0] VERDICT_PRIORITY   = 3'd3;
    localparam logic [2:0] VERDICT_NOT_SURE   = 3'd4;

    localparam logic ACTION_PUSH = 1'b0;
    localparam logic ACTION_POP  = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } in_req_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic       overflow;
    } out_req_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture input request, do stack/queue part
        logic up_start;    // begin sift up
        logic up_step;     // issue read of parent
        logic up_eval;     // compare parent, move or place
        logic dn_start;    // begin sift down (latch last element)
        logic dn_rd;       // issue first child read
        logic dn_rd2;      // issue second child read
        logic dn_eval;     // compare children, move or place
        logic top_rd;      // read heap top
        logic top_chk;     // check heap top against popped value
        logic place;       // write the moving value into the hole
        logic finish;      // form verdict, clear case if last
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic is_pop;
        logic is_last;
        logic full;
        logic empty;
        logic up_done;
        logic dn_done;
        logic need_dn;
    } sts_t;
endpackage

// File: sv/ppdc_ram.sv
// Generic single-port-write, single-read RAM with registered read
`timescale 1ns / 1ps
module ppdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/ppdc_ctrl.sv
// Controller state machine: sequences push, pop, heap sift and verdict
`timescale 1ns / 1ps
module ppdc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  logic          out_busy,
    input  ppdc_pkg::sts_t sts,
    output ppdc_pkg::ctl_t ctl,
    output logic          idle
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_UPRD   = 4'd2;
    localparam logic [3:0] S_UPWT   = 4'd3;
    localparam logic [3:0] S_UPEV   = 4'd4;
    localparam logic [3:0] S_TOPWT  = 4'd5;
    localparam logic [3:0] S_TOPCK  = 4'd6;
    localparam logic [3:0] S_DNWT   = 4'd7;
    localparam logic [3:0] S_DNRD   = 4'd8;
    localparam logic [3:0] S_DNRD2  = 4'd9;
    localparam logic [3:0] S_DNWT2  = 4'd10;
    localparam logic [3:0] S_DNEV   = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        idle       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (!sts.is_pop)
                begin
                    if (sts.full)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ctl.up_start = 1'b1;
                        state_next   = S_UPRD;
                    end
                end
                else if (sts.empty)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.top_rd = 1'b1;
                    state_next = S_TOPWT;
                end
            end
            S_UPRD:
            begin
                if (sts.up_done)
                begin
                    ctl.place  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.up_step = 1'b1;
                    state_next  = S_UPWT;
                end
            end
            S_UPWT:  state_next = S_UPEV;
            S_UPEV:
            begin
                ctl.up_eval = 1'b1;
                state_next  = S_UPRD;
            end
            S_TOPWT: state_next = S_TOPCK;
            S_TOPCK:
            begin
                ctl.top_chk = 1'b1;
                if (sts.need_dn)
                begin
                    state_next = S_DNWT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DNWT:
            begin
                ctl.dn_start = 1'b1;
                state_next   = S_DNRD;
            end
            S_DNRD:
            begin
                if (sts.dn_done)
                begin
                    ctl.place  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.dn_rd  = 1'b1;
                    state_next = S_DNRD2;
                end
            end
            S_DNRD2:
            begin
                ctl.dn_rd2 = 1'b1;
                state_next = S_DNWT2;
            end
            S_DNWT2: state_next = S_DNEV;
            S_DNEV:
            begin
                ctl.dn_eval = 1'b1;
                state_next  = S_DNRD;
            end
            S_FIN:
            begin
                if (!sts.is_last || !out_busy)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// File: sv/ppdc_dp.sv
// Datapath: stores, pointers, heap sift unit, flags and verdict register
`timescale 1ns / 1ps
module ppdc_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  ppdc_pkg::in_req_t in_req,
    input  ppdc_pkg::ctl_t    ctl,
    output ppdc_pkg::sts_t    sts,
    output logic              out_set,
    output ppdc_pkg::out_req_t out_data
);
    localparam int AB = ppdc_pkg::ADDR_BITS;
    localparam int CB = ppdc_pkg::CNT_BITS;
    localparam int VB = ppdc_pkg::VALUE_BITS;

    ppdc_pkg::in_req_t req_reg;
    logic [CB-1:0] fill_reg;
    logic [AB-1:0] head_reg, tail_reg;
    logic still_lifo_reg, still_fifo_reg, still_heap_reg, ovf_reg;
    logic [CB-1:0] pos_reg;     // current hole position
    logic [CB-1:0] n_reg;       // heap size during sift down
    logic [VB-1:0] v_reg;       // value being placed
    logic [VB-1:0] c1_reg;      // left child value

    // Heap RAM port control
    logic          h_we;
    logic [AB-1:0] h_wa, h_ra;
    logic [VB-1:0] h_wd, h_rd;
    logic [AB-1:0] h_ra_reg;
    logic [VB-1:0] l_rd, f_rd;

    logic [CB-1:0] parent, child1, child2;
    logic          full, empty;
    logic          c2_ok;

    assign full   = (fill_reg == CB'(ppdc_pkg::DEPTH));
    assign empty  = (fill_reg == '0);
    assign parent = (pos_reg - CB'(1)) >> 1;
    assign child1 = {pos_reg[CB-2:0], 1'b1};
    assign child2 = child1 + CB'(1);
    assign c2_ok  = (child2 < n_reg);

    // Stack and queue reads are issued on every clock from the live pointers
    ppdc_ram #(.WIDTH(VB), .DEPTH(ppdc_pkg::DEPTH)) u_lifo (
        .clk(clk),
        .we(ctl.load && in_req.action == ppdc_pkg::ACTION_PUSH && !full),
        .waddr(fill_reg[AB-1:0]), .wdata(in_req.value),
        .raddr(AB'(fill_reg - CB'(1))), .rdata(l_rd)
    );
    ppdc_ram #(.WIDTH(VB), .DEPTH(ppdc_pkg::DEPTH)) u_fifo (
        .clk(clk),
        .we(ctl.load && in_req.action == ppdc_pkg::ACTION_PUSH && !full),
        .waddr(tail_reg), .wdata(in_req.value),
        .raddr(head_reg), .rdata(f_rd)
    );
    ppdc_ram #(.WIDTH(VB), .DEPTH(ppdc_pkg::DEPTH)) u_heap (
        .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd),
        .raddr(h_ra), .rdata(h_rd)
    );

    always_comb
    begin
        h_we = 1'b0;
        h_wa = pos_reg[AB-1:0];
        h_wd = v_reg;
        h_ra = h_ra_reg;
        if (ctl.up_step)
        begin
            h_ra = parent[AB-1:0];
        end
        else if (ctl.top_rd)
        begin
            h_ra = '0;
        end
        else if (ctl.dn_rd)
        begin
            h_ra = child1[AB-1:0];
        end
        else if (ctl.dn_rd2)
        begin
            h_ra = child2[AB-1:0];
        end
        else if (ctl.top_chk)
        begin
            h_ra = AB'(fill_reg - CB'(1));
        end
        if (ctl.up_eval)
        begin
            h_we = 1'b1;
            h_wd = (h_rd >= v_reg) ? v_reg : h_rd;
        end
        else if (ctl.dn_eval)
        begin
            h_we = 1'b1;
            if (c2_ok && h_rd > c1_reg)
            begin
                h_wd = (h_rd > v_reg) ? h_rd : v_reg;
            end
            else
            begin
                h_wd = (c1_reg > v_reg) ? c1_reg : v_reg;
            end
        end
        else if (ctl.place)
        begin
            // Drop the moving value into the hole where the sift ended
            h_we = 1'b1;
        end
    end

    logic up_done_reg, dn_done_reg;

    always_ff @(posedge clk)
    begin
        h_ra_reg <= h_ra;
        if (ctl.load)
        begin
            req_reg <= in_req;
        end
        if (ctl.up_start)
        begin
            pos_reg <= fill_reg - CB'(1);
            v_reg   <= req_reg.value;
        end
        if (ctl.up_eval)
        begin
            if (h_rd >= v_reg)
            begin
                pos_reg <= pos_reg;
            end
            else
            begin
                pos_reg <= parent;
            end
        end
        if (ctl.top_chk)
        begin
            pos_reg <= '0;
            n_reg   <= fill_reg - CB'(1);
        end
        if (ctl.dn_start)
        begin
            v_reg <= h_rd;
        end
        if (ctl.dn_rd2)
        begin
            c1_reg <= h_rd;
        end
        if (ctl.dn_eval)
        begin
            if (c2_ok && h_rd > c1_reg)
            begin
                if (h_rd > v_reg)
                begin
                    pos_reg <= child2;
                end
            end
            else if (c1_reg > v_reg)
            begin
                pos_reg <= child1;
            end
        end
    end

    // Sift termination flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_done_reg <= 1'b0;
            dn_done_reg <= 1'b0;
        end
        else
        begin
            if (ctl.up_start)
            begin
                up_done_reg <= (fill_reg == CB'(1));
            end
            else if (ctl.up_eval)
            begin
                up_done_reg <= (h_rd >= v_reg) || (parent == '0);
            end
            if (ctl.top_chk)
            begin
                dn_done_reg <= (fill_reg <= CB'(2));
            end
            else if (ctl.dn_eval)
            begin
                if (c2_ok && h_rd > c1_reg)
                begin
                    dn_done_reg <= !(h_rd > v_reg) || ({child2[CB-2:0], 1'b1} >= n_reg);
                end
                else
                begin
                    dn_done_reg <= !(c1_reg > v_reg) || ({child1[CB-2:0], 1'b1} >= n_reg);
                end
            end
        end
    end

    logic pop_empty_reg, drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            still_lifo_reg <= 1'b1;
            still_fifo_reg <= 1'b1;
            still_heap_reg <= 1'b1;
            ovf_reg        <= 1'b0;
            pop_empty_reg  <= 1'b0;
            drop_reg       <= 1'b0;
        end
        else
        begin
            if (ctl.load)
            begin
                pop_empty_reg <= (in_req.action == ppdc_pkg::ACTION_POP) && empty;
                drop_reg      <= (in_req.action == ppdc_pkg::ACTION_PUSH) && full;
                if (in_req.action == ppdc_pkg::ACTION_PUSH)
                begin
                    if (full)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        tail_reg <= tail_reg + AB'(1);
                        fill_reg <= fill_reg + CB'(1);
                    end
                end
            end
            if (ctl.top_chk)
            begin
                if (l_rd != req_reg.value)
                begin
                    still_lifo_reg <= 1'b0;
                end
                if (f_rd != req_reg.value)
                begin
                    still_fifo_reg <= 1'b0;
                end
                if (h_rd != req_reg.value)
                begin
                    still_heap_reg <= 1'b0;
                end
                head_reg <= head_reg + AB'(1);
                fill_reg <= fill_reg - CB'(1);
            end
            if (ctl.finish)
            begin
                if (req_reg.last)
                begin
                    fill_reg       <= '0;
                    head_reg       <= '0;
                    tail_reg       <= '0;
                    still_lifo_reg <= 1'b1;
                    still_fifo_reg <= 1'b1;
                    still_heap_reg <= 1'b1;
                    ovf_reg        <= 1'b0;
                end
                else if (pop_empty_reg)
                begin
                    still_lifo_reg <= 1'b0;
                    still_fifo_reg <= 1'b0;
                    still_heap_reg <= 1'b0;
                end
            end
        end
    end

    logic vf_l, vf_f, vf_h;
    logic [2:0] vsel;
    always_comb
    begin
        vf_l = still_lifo_reg && !pop_empty_reg;
        vf_f = still_fifo_reg && !pop_empty_reg;
        vf_h = still_heap_reg && !pop_empty_reg;
        if (vf_l && !vf_f && !vf_h)
        begin
            vsel = ppdc_pkg::VERDICT_STACK;
        end
        else if (!vf_l && vf_f && !vf_h)
        begin
            vsel = ppdc_pkg::VERDICT_QUEUE;
        end
        else if (!vf_l && !vf_f && vf_h)
        begin
            vsel = ppdc_pkg::VERDICT_PRIORITY;
        end
        else if (!vf_l && !vf_f && !vf_h)
        begin
            vsel = ppdc_pkg::VERDICT_IMPOSSIBLE;
        end
        else
        begin
            vsel = ppdc_pkg::VERDICT_NOT_SURE;
        end
    end

    assign out_set           = ctl.finish && req_reg.last;
    assign out_data.verdict  = vsel;
    assign out_data.overflow = ovf_reg;

    assign sts.is_pop  = req_reg.action;
    assign sts.is_last = req_reg.last;
    assign sts.full    = drop_reg;
    assign sts.empty   = pop_empty_reg;
    assign sts.up_done = up_done_reg;
    assign sts.dn_done = dn_done_reg;
    assign sts.need_dn = (fill_reg > CB'(1));
endmodule

// File: sv/push_pop_discipline_checker_top.sv
// Top level: push/pop discipline checker with request channels in and out
`timescale 1ns / 1ps
// Usage:
//   in_valid/in_ready/in_req carry one push or pop request (action, value,
//   last). A push with room enters a stack, a queue and a max-heap; a pop
//   on a non-empty store is compared with stack top, queue head and heap max.
//   out_valid/out_ready/out_req carry one verdict per case, issued on the
//   request marked last, with the sticky overflow flag.
// Timing:
//   One request at a time; in_ready is high only while the block waits.
//   A dropped push or a pop on empty goes straight to the verdict; a push
//   sifts its value up the heap level by level; a pop reads and checks the
//   heap top and then, unless it empties the store, sifts the last element
//   down level by level. The block is ready again in the same cycle that a
//   verdict, if any, shows on out_valid.
// Reset:
//   rst_n clears counts, pointers and flags; the stores need no clearing,
//   since only written entries are read. The block is ready at once.
// Stall:
//   A finished verdict waits in the output register; the next request is
//   accepted meanwhile, and only a further verdict waits for out_ready.
module push_pop_discipline_checker_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ppdc_pkg::in_req_t  in_req,
    output logic               out_valid,
    input  logic               out_ready,
    output ppdc_pkg::out_req_t out_req
);
    ppdc_pkg::ctl_t     ctl;
    ppdc_pkg::sts_t     sts;
    ppdc_pkg::out_req_t res;
    logic               res_set, idle;
    logic               out_valid_reg;
    ppdc_pkg::out_req_t out_req_reg;

    // Hold a verdict until taken; the controller waits only when a new one
    // arrives while the old one is still held.
    assign in_ready = idle;

    ppdc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(in_valid && in_ready),
        .out_busy(out_valid_reg && !out_ready),
        .sts(sts), .ctl(ctl), .idle(idle)
    );

    ppdc_dp u_dp (
        .clk(clk), .rst_n(rst_n), .in_req(in_req), .ctl(ctl),
        .sts(sts), .out_set(res_set), .out_data(res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_set)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_set)
        begin
            out_req_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_req   = out_req_reg;
endmodule

// File: sv/ppdc_checker.sv
// Port-level checker for the push/pop discipline checker, with bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ppdc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input ppdc_pkg::in_req_t  in_req,
    input logic               out_valid,
    input logic               out_ready,
    input ppdc_pkg::out_req_t out_req
);
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_req), "verdict dropped while stalled")
    `CHK_IMPLY(a_verdict_range, clk, rst_n, out_valid, out_req.verdict <= ppdc_pkg::VERDICT_NOT_SURE, "verdict code out of range")
    `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "request accepted while busy")
    `CHK_NEXT(a_no_verdict_without_last, clk, rst_n, !out_valid && in_valid && in_ready && !in_req.last, !out_valid, "verdict without last request")
endmodule

bind push_pop_discipline_checker_top ppdc_checker u_ppdc_checker (.*);
